@@ sv/pfba_pkg.sv @@
// ----------------------------------------------------------------------------
// Page frame bitmap allocator package
// Shared constants, action codes, controller/datapath command and status
// structures and the lowest-zero search used by the allocation scan.
// ----------------------------------------------------------------------------
package pfba_pkg;

  localparam int NUM_PAGES  = 1048576;
  localparam int PAGE_SHIFT = 12;

  localparam int ADDR_W   = 32;
  localparam int EXT_W    = ADDR_W + 1;
  localparam int COUNT_W  = 21;
  localparam int ACTION_W = 2;

  localparam int WORD_W    = 32;
  localparam int WBIT_W    = 5;
  localparam int NUM_WORDS = (NUM_PAGES + WORD_W - 1) / WORD_W;
  localparam int WA_W      = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int PG_W      = WA_W + WBIT_W + 1;

  localparam logic [EXT_W-1:0]   PAGE_MASK = EXT_W'((64'd1 << PAGE_SHIFT) - 64'd1);
  localparam logic [EXT_W-1:0]   PAGES_EXT = EXT_W'(NUM_PAGES);
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
  localparam logic [WA_W-1:0]    LAST_WORD = WA_W'(NUM_WORDS - 1);

  localparam logic [ACTION_W-1:0] ACT_FREE_RANGE = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_USE_RANGE  = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_ALLOC      = 2'd2;
  localparam logic [ACTION_W-1:0] ACT_FREE_PAGE  = 2'd3;

  typedef struct packed {
    logic load;
    logic clr_wr;
    logic rd;
    logic wc_inc;
    logic rng_wr;
    logic hit;
    logic alloc_wr;
    logic fail;
    logic free_wr;
    logic res;
  } pfba_cmd_t;

  typedef struct packed {
    logic wc_max;
    logic rng_empty;
    logic mask_full;
    logic wc_last;
    logic scan_hit;
    logic zero_page;
    logic scan_end;
    logic free_ok;
    logic out_free;
  } pfba_sts_t;

  function automatic logic [PG_W-1:0] clamp_pg(input logic [EXT_W-1:0] p);
    return (p > PAGES_EXT) ? PG_W'(NUM_PAGES) : PG_W'(p);
  endfunction

  function automatic logic [WBIT_W-1:0] lowest_zero(input logic [WORD_W-1:0] w);
    logic [WORD_W-1:0] inv;
    logic [WORD_W-1:0] iso;
    logic [WBIT_W-1:0] idx;
    inv = ~w;
    iso = inv & (~inv + 1'b1);
    idx = '0;
    for (int i = 0; i < WORD_W; i++) begin
      if (iso[i]) begin
        idx = idx | WBIT_W'(i);
      end
    end
    return idx;
  endfunction

endpackage

@@ sv/pfba_ctrl.sv @@
// ----------------------------------------------------------------------------
// Page frame bitmap allocator controller
// State machine that runs the clearing pass, the range walks, the allocation
// scan, single page frees and the hand-off of each result word.
// ----------------------------------------------------------------------------
module pfba_ctrl (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic [pfba_pkg::ACTION_W-1:0]   in_action,
  output logic                            in_stall,
  input  pfba_pkg::pfba_sts_t             sts,
  output pfba_pkg::pfba_cmd_t             cmd
);

  localparam logic [3:0] ST_CLR      = 4'd0;
  localparam logic [3:0] ST_IDLE     = 4'd1;
  localparam logic [3:0] ST_RNG      = 4'd2;
  localparam logic [3:0] ST_RNG_WR   = 4'd3;
  localparam logic [3:0] ST_SCAN0    = 4'd4;
  localparam logic [3:0] ST_SCAN     = 4'd5;
  localparam logic [3:0] ST_ALLOC_WR = 4'd6;
  localparam logic [3:0] ST_FREE_RD  = 4'd7;
  localparam logic [3:0] ST_FREE_WR  = 4'd8;
  localparam logic [3:0] ST_RES      = 4'd9;

  logic [3:0] state_r;
  logic [3:0] state_nxt;

  assign in_stall = (state_r != ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_CLR: begin
        cmd.clr_wr = 1'b1;
        cmd.wc_inc = 1'b1;
        if (sts.wc_max) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          case (in_action)
            pfba_pkg::ACT_ALLOC:     state_nxt = ST_SCAN0;
            pfba_pkg::ACT_FREE_PAGE: state_nxt = ST_FREE_RD;
            default:                 state_nxt = ST_RNG;
          endcase
        end
      end
      ST_RNG: begin
        if (sts.rng_empty) begin
          state_nxt = ST_RES;
        end else if (sts.mask_full) begin
          cmd.rng_wr = 1'b1;
          if (sts.wc_last) begin
            state_nxt = ST_RES;
          end else begin
            cmd.wc_inc = 1'b1;
          end
        end else begin
          cmd.rd    = 1'b1;
          state_nxt = ST_RNG_WR;
        end
      end
      ST_RNG_WR: begin
        cmd.rng_wr = 1'b1;
        if (sts.wc_last) begin
          state_nxt = ST_RES;
        end else begin
          cmd.wc_inc = 1'b1;
          state_nxt  = ST_RNG;
        end
      end
      ST_SCAN0: begin
        cmd.rd     = 1'b1;
        cmd.wc_inc = 1'b1;
        state_nxt  = ST_SCAN;
      end
      ST_SCAN: begin
        if (sts.scan_hit) begin
          if (sts.zero_page) begin
            cmd.fail  = 1'b1;
            state_nxt = ST_RES;
          end else begin
            cmd.hit   = 1'b1;
            state_nxt = ST_ALLOC_WR;
          end
        end else if (sts.scan_end) begin
          cmd.fail  = 1'b1;
          state_nxt = ST_RES;
        end else begin
          cmd.rd     = 1'b1;
          cmd.wc_inc = 1'b1;
        end
      end
      ST_ALLOC_WR: begin
        cmd.alloc_wr = 1'b1;
        state_nxt    = ST_RES;
      end
      ST_FREE_RD: begin
        if (sts.free_ok) begin
          cmd.rd    = 1'b1;
          state_nxt = ST_FREE_WR;
        end else begin
          state_nxt = ST_RES;
        end
      end
      ST_FREE_WR: begin
        cmd.free_wr = 1'b1;
        state_nxt   = ST_RES;
      end
      ST_RES: begin
        if (sts.out_free) begin
          cmd.res   = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLR;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_accept_starts_work: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r != ST_IDLE && state_r != ST_CLR))
    else $error("accepted word did not start an operation");

  a_res_only_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.res |-> sts.out_free)
    else $error("result loaded while the output register was occupied");

  a_single_write: assert property (@(posedge clk) disable iff (!rst_n)
    $countones({cmd.clr_wr, cmd.rng_wr, cmd.alloc_wr, cmd.free_wr}) <= 1)
    else $error("more than one bitmap write command in a cycle");

endmodule

@@ sv/pfba_dp.sv @@
// ----------------------------------------------------------------------------
// Page frame bitmap allocator datapath
// Bitmap memory of 32-bit words, page bound decoding, range masks, the
// lowest-free search, the handed-out page count and the output register.
// ----------------------------------------------------------------------------
module pfba_dp (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [pfba_pkg::ACTION_W-1:0]   in_action,
  input  logic [pfba_pkg::ADDR_W-1:0]     in_address,
  input  logic [pfba_pkg::ADDR_W-1:0]     in_range_end,
  input  pfba_pkg::pfba_cmd_t             cmd,
  output pfba_pkg::pfba_sts_t             sts,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_status,
  output logic [pfba_pkg::ADDR_W-1:0]     out_page_addr,
  output logic [pfba_pkg::COUNT_W-1:0]    out_used_count
);

  localparam int WORD_W = pfba_pkg::WORD_W;
  localparam int WBIT_W = pfba_pkg::WBIT_W;
  localparam int WA_W   = pfba_pkg::WA_W;
  localparam int PG_W   = pfba_pkg::PG_W;
  localparam int EXT_W  = pfba_pkg::EXT_W;
  localparam int ADDR_W = pfba_pkg::ADDR_W;

  logic [WORD_W-1:0] map_mem [pfba_pkg::NUM_WORDS];

  logic [pfba_pkg::ACTION_W-1:0] action_r;
  logic [PG_W-1:0]               first_r;
  logic [PG_W-1:0]               last_r;
  logic                          free_ok_r;
  logic [WA_W-1:0]               wc_r;
  logic [WA_W-1:0]               dw_r;
  logic [WORD_W-1:0]             rdata_r;
  logic                          res_status_r;
  logic [ADDR_W-1:0]             res_page_r;
  logic [pfba_pkg::COUNT_W-1:0]  count_r;
  logic                          out_valid_r;
  logic                          out_status_r;
  logic [ADDR_W-1:0]             out_page_addr_r;
  logic [pfba_pkg::COUNT_W-1:0]  out_used_count_r;

  logic [EXT_W-1:0]  start_up;
  logic [EXT_W-1:0]  start_dn;
  logic [EXT_W-1:0]  end_pg;
  logic [PG_W-1:0]   first_nxt;
  logic [PG_W-1:0]   lmo;
  logic [WA_W-1:0]   fw;
  logic [WA_W-1:0]   lw;
  logic [WBIT_W-1:0] lo;
  logic [WBIT_W-1:0] hi;
  logic [WORD_W-1:0] rng_mask;
  logic [WORD_W-1:0] rng_data;
  logic [WORD_W-1:0] bit_mask;
  logic [WBIT_W-1:0] lz;
  logic [ADDR_W+PG_W-1:0] page_wide;
  logic              mem_we;
  logic [WORD_W-1:0] mem_wdata;

  assign start_up  = ({1'b0, in_address} + pfba_pkg::PAGE_MASK) >> pfba_pkg::PAGE_SHIFT;
  assign start_dn  = EXT_W'(in_address >> pfba_pkg::PAGE_SHIFT);
  assign end_pg    = EXT_W'(in_range_end >> pfba_pkg::PAGE_SHIFT);
  assign first_nxt = pfba_pkg::clamp_pg((in_action == pfba_pkg::ACT_FREE_RANGE) ?
                                        start_up : start_dn);

  assign lmo      = last_r - 1'b1;
  assign fw       = first_r[WBIT_W +: WA_W];
  assign lw       = lmo[WBIT_W +: WA_W];
  assign lo       = (wc_r == fw) ? first_r[WBIT_W-1:0] : '0;
  assign hi       = (wc_r == lw) ? lmo[WBIT_W-1:0] : '1;
  assign rng_mask = ({WORD_W{1'b1}} << lo) &
                    ({WORD_W{1'b1}} >> (WBIT_W'(WORD_W - 1) - hi));
  assign rng_data = (action_r == pfba_pkg::ACT_USE_RANGE) ? (rdata_r | rng_mask) :
                                                            (rdata_r & ~rng_mask);
  assign bit_mask = WORD_W'(1) << first_r[WBIT_W-1:0];
  assign lz       = pfba_pkg::lowest_zero(rdata_r);
  assign page_wide = {{ADDR_W{1'b0}}, first_r} << pfba_pkg::PAGE_SHIFT;

  always_comb begin
    mem_we    = cmd.clr_wr | cmd.rng_wr | cmd.alloc_wr | cmd.free_wr;
    mem_wdata = {WORD_W{1'b1}};
    if (cmd.rng_wr) begin
      mem_wdata = rng_data;
    end else if (cmd.alloc_wr) begin
      mem_wdata = rdata_r | bit_mask;
    end else if (cmd.free_wr) begin
      mem_wdata = rdata_r & ~bit_mask;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      map_mem[wc_r] <= mem_wdata;
    end
    if (cmd.rd) begin
      rdata_r <= map_mem[wc_r];
      dw_r    <= wc_r;
    end
  end

  always_comb begin
    sts.wc_max    = (wc_r == pfba_pkg::LAST_WORD);
    sts.rng_empty = (first_r >= last_r);
    sts.mask_full = &rng_mask;
    sts.wc_last   = (wc_r == lw);
    sts.scan_hit  = (rdata_r != {WORD_W{1'b1}});
    sts.zero_page = (dw_r == '0) && (lz == '0);
    sts.scan_end  = (dw_r == pfba_pkg::LAST_WORD);
    sts.free_ok   = free_ok_r;
    sts.out_free  = !out_valid_r || !out_stall;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      action_r     <= in_action;
      first_r      <= first_nxt;
      last_r       <= pfba_pkg::clamp_pg(end_pg);
      free_ok_r    <= (start_dn < pfba_pkg::PAGES_EXT);
      res_status_r <= 1'b0;
      res_page_r   <= '0;
    end else begin
      if (cmd.hit) begin
        first_r <= {1'b0, dw_r, lz};
      end
      if (cmd.fail) begin
        res_status_r <= 1'b1;
      end
      if (cmd.alloc_wr) begin
        res_page_r <= page_wide[ADDR_W-1:0];
      end
    end
    if (cmd.res) begin
      out_status_r     <= res_status_r;
      out_page_addr_r  <= res_page_r;
      out_used_count_r <= count_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wc_r        <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.load) begin
        wc_r <= (in_action == pfba_pkg::ACT_ALLOC) ? '0 : first_nxt[WBIT_W +: WA_W];
      end else if (cmd.hit) begin
        wc_r <= dw_r;
      end else if (cmd.wc_inc) begin
        wc_r <= wc_r + 1'b1;
      end
      if (cmd.alloc_wr && count_r != pfba_pkg::COUNT_MAX) begin
        count_r <= count_r + 1'b1;
      end else if (cmd.free_wr && count_r != '0) begin
        count_r <= count_r - 1'b1;
      end
      if (cmd.res) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_page_addr  = out_page_addr_r;
  assign out_used_count = out_used_count_r;

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (count_r == $past(count_r) ||
                      count_r == $past(count_r) + 1'b1 ||
                      count_r == $past(count_r) - 1'b1))
    else $error("page count moved by more than one");

  a_alloc_bit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.alloc_wr |-> ((rdata_r & bit_mask) == '0))
    else $error("allocation marked a page that was already used");

  a_free_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.free_wr |-> free_ok_r)
    else $error("page free written for a page beyond the bitmap");

endmodule

@@ sv/page_frame_bitmap_allocator.sv @@
// ----------------------------------------------------------------------------
// Page frame bitmap allocator
// First-fit page frame allocator over a bitmap with one used bit per page.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass over all NUM_WORDS words,
// setting every page to used, and takes no word meanwhile. The bitmap is a
// single-port memory of 32-bit words, and every operation walks it one word
// access at a time: a range mark writes each fully covered word directly and
// reads and then writes back each partly covered word, and an empty range
// goes straight to the result; allocate reads one word per cycle from word 0
// up to the first word holding a free page and, when it succeeds, writes that
// word back with the page marked used; a page free reads the word and writes
// it back with the page's bit cleared, or skips both when the page lies
// beyond the bitmap. One word is in work at a time, and a finished result
// waits in the output register while the next word is taken.
// ----------------------------------------------------------------------------
module page_frame_bitmap_allocator (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [pfba_pkg::ACTION_W-1:0]   in_action,
  input  logic [pfba_pkg::ADDR_W-1:0]     in_address,
  input  logic [pfba_pkg::ADDR_W-1:0]     in_range_end,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_status,
  output logic [pfba_pkg::ADDR_W-1:0]     out_page_addr,
  output logic [pfba_pkg::COUNT_W-1:0]    out_used_count
);

  pfba_pkg::pfba_cmd_t cmd;
  pfba_pkg::pfba_sts_t sts;

  pfba_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_action (in_action),
    .in_stall  (in_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  pfba_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_action      (in_action),
    .in_address     (in_address),
    .in_range_end   (in_range_end),
    .cmd            (cmd),
    .sts            (sts),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_status     (out_status),
    .out_page_addr  (out_page_addr),
    .out_used_count (out_used_count)
  );

endmodule
